[src/iti_pkg.sv]
// shared types, sizes and byte classes for the identifier tokenizer
package iti_pkg;

  localparam int POOL_BYTES   = 128;
  localparam int SYM_ENTRIES  = 64;
  localparam int HASH_BUCKETS = 16;  // power of two: bucket is the low bits of the sum

  localparam int POOL_AW = $clog2(POOL_BYTES);
  localparam int PTR_W   = POOL_AW + 1;
  localparam int SYM_AW  = $clog2(SYM_ENTRIES);
  localparam int CNT_W   = SYM_AW + 1;
  localparam int BKT_W   = $clog2(HASH_BUCKETS);

  localparam logic [1:0] ST_NEW    = 2'd0;
  localparam logic [1:0] ST_EXISTS = 2'd1;
  localparam logic [1:0] ST_DIGIT  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic               we;
    logic [POOL_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [POOL_AW-1:0] raddr_a;
    logic [POOL_AW-1:0] raddr_b;
  } pool_req_t;

  function automatic logic is_sep(input logic [7:0] c);
    return c == CH_SPACE || c == CH_COMMA || c == CH_SEMI || c == CH_TAB ||
           c == CH_LF || c == CH_CR || c == CH_NUL;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

endpackage

[src/iti_pool.sv]
// string pool: one write port, two registered read ports
module iti_pool (
  input  logic              clk,
  input  iti_pkg::pool_req_t req,
  output logic [7:0]        rd_a,
  output logic [7:0]        rd_b
);
  import iti_pkg::*;

  logic [7:0] mem [POOL_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

[src/identifier_tokenize_and_intern_core.sv]
// top level: tokenizer, chained hash lookup and symbol table
//
// Bytes arrive one word per cycle on the slave side while idle (tdata = char_code,
// tuser = kind). A plain byte goes to the pool as it is taken, unless the pool is full.
// A word that ends a token starts the lookup sequencer: the bucket head is read, then
// each chain entry is read and its length checked, and on a length match one pair of
// pool reads is issued and checked per byte; a commit state follows. A result then
// waits in the output register until taken, and the block takes no word meanwhile.
// A word whose token ended and which finds the pool still full gives a second result.
// The hash is the byte sum kept as the token arrives, so no pass over it is needed.
module identifier_tokenize_and_intern_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code[7:0]
  input  logic [0:0]  s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // symbol_index[5:0], bucket[9:6], token_length[16:10],
                                 // pool_offset[23:17]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast    // last_result
);
  import iti_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FIN  = 8'b0000_0010,
    S_LINK = 8'b0000_0100,
    S_META = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_CMP  = 8'b0010_0000,
    S_DONE = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t             state;
  logic [PTR_W-1:0]   wp;
  logic [PTR_W-1:0]   ts;
  logic [CNT_W-1:0]   cnt;
  logic [BKT_W-1:0]   sum;
  logic               first_dig;
  logic [CNT_W-1:0]   head [HASH_BUCKETS];
  logic [7:0]         st_byte;
  logic               st_pend;
  logic [CNT_W-1:0]   link_r;
  logic [PTR_W-1:0]   cmp_i;
  logic               more2;

  logic [POOL_AW-1:0] sym_start [SYM_ENTRIES];
  logic [PTR_W-1:0]   sym_len   [SYM_ENTRIES];
  logic [CNT_W-1:0]   chain     [SYM_ENTRIES];
  logic [POOL_AW-1:0] e_start;
  logic [PTR_W-1:0]   e_len;
  logic [CNT_W-1:0]   e_link;

  logic [1:0]         o_status;
  logic [SYM_AW-1:0]  o_idx;
  logic [BKT_W-1:0]   o_bkt;
  logic [6:0]         o_len;
  logic [6:0]         o_off;
  logic               o_last;

  pool_req_t          preq;
  logic [7:0]         rd_a;
  logic [7:0]         rd_b;

  iti_pool u_pool (.clk(clk), .req(preq), .rd_a(rd_a), .rd_b(rd_b));

  logic               acc;
  logic               in_kind;
  logic               in_sep;
  logic               pending;
  logic               need_fin;
  logic               in_store;
  logic [PTR_W-1:0]   tok_len;
  logic [SYM_AW-1:0]  e_addr;

  // finish-of-token outcome, shared by the reject path and the commit path
  logic               fin_go;
  logic [1:0]         fin_status;
  logic [PTR_W-1:0]   fin_wp;
  logic               fin_room;

  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign in_kind  = s_tuser[0];
  assign in_sep   = !in_kind && is_sep(s_tdata);
  assign pending  = ts < wp;
  assign need_fin = pending && (in_kind || in_sep || wp[PTR_W-1]);
  assign in_store = !in_kind && !in_sep;
  assign tok_len  = wp - ts;
  assign e_addr   = SYM_AW'(link_r - CNT_W'(1));

  always_comb begin
    fin_go     = 1'b0;
    fin_status = ST_NEW;
    fin_wp     = wp;
    unique case (state)
      S_FIN: begin
        if (first_dig) begin
          fin_go     = 1'b1;
          fin_status = ST_DIGIT;
          fin_wp     = ts;
        end else if (cnt[CNT_W-1]) begin
          fin_go     = 1'b1;
          fin_status = ST_FULL;
          fin_wp     = ts;
        end
      end
      S_DONE: begin
        fin_go     = 1'b1;
        fin_status = more2 ? ST_EXISTS : ST_NEW;  // more2 holds the match flag here
      end
      default: ;
    endcase
    fin_room = !fin_wp[PTR_W-1];
  end

  always_comb begin
    preq         = '0;
    preq.raddr_a = POOL_AW'(PTR_W'(e_start) + cmp_i);
    preq.raddr_b = POOL_AW'(ts + cmp_i);
    if (acc && !need_fin && in_store && !wp[PTR_W-1]) begin
      preq.we    = 1'b1;
      preq.waddr = POOL_AW'(wp);
      preq.wdata = s_tdata;
    end else if (fin_go && st_pend && fin_room) begin
      preq.we    = 1'b1;
      preq.waddr = POOL_AW'(fin_wp);
      preq.wdata = st_byte;
    end
  end

  // symbol table: registered read at the chain entry, write on commit
  always_ff @(posedge clk) begin
    if (state == S_LINK) begin
      e_start <= sym_start[e_addr];
      e_len   <= sym_len[e_addr];
      e_link  <= chain[e_addr];
    end
    if (state == S_DONE) begin
      sym_start[SYM_AW'(cnt)] <= POOL_AW'(ts);
      sym_len[SYM_AW'(cnt)]   <= tok_len;
      if (!more2) begin
        chain[SYM_AW'(cnt)] <= head[sum];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      ts        <= '0;
      cnt       <= '0;
      sum       <= '0;
      first_dig <= 1'b0;
      more2     <= 1'b0;
      m_tvalid  <= 1'b0;
      for (int i = 0; i < HASH_BUCKETS; i++) begin
        head[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            st_byte <= s_tdata;
            st_pend <= in_store;
            if (need_fin) begin
              state <= S_FIN;
            end else if (in_store) begin
              if (!wp[PTR_W-1]) begin
                wp <= wp + PTR_W'(1);
                if (wp == ts) begin
                  sum       <= s_tdata[BKT_W-1:0];
                  first_dig <= is_digit(s_tdata);
                end else begin
                  sum <= sum + s_tdata[BKT_W-1:0];
                end
              end else begin
                o_status <= ST_FULL;
                o_idx    <= '0;
                o_bkt    <= '0;
                o_len    <= '0;
                o_off    <= '0;
                o_last   <= 1'b1;
                m_tvalid <= 1'b1;
                more2    <= 1'b0;
                state    <= S_OUT;
              end
            end
          end
        end
        S_FIN: begin
          if (!fin_go) begin
            link_r <= head[sum];
            more2  <= 1'b0;
            state  <= S_LINK;
          end
        end
        S_LINK: begin
          state <= (link_r == '0) ? S_DONE : S_META;
        end
        S_META: begin
          if (e_len == tok_len) begin
            cmp_i <= '0;
            state <= S_RD;
          end else begin
            link_r <= e_link;
            state  <= S_LINK;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (rd_a != rd_b) begin
            link_r <= e_link;
            state  <= S_LINK;
          end else if (cmp_i == tok_len - PTR_W'(1)) begin
            more2 <= 1'b1;
            state <= S_DONE;
          end else begin
            cmp_i <= cmp_i + PTR_W'(1);
            state <= S_RD;
          end
        end
        S_DONE: begin
          cnt <= cnt + CNT_W'(1);
          if (!more2) begin
            head[sum] <= {1'b0, cnt[SYM_AW-1:0]} + CNT_W'(1);
          end
        end
        S_OUT: begin
          if (m_tready) begin
            if (more2) begin
              o_status <= ST_FULL;
              o_idx    <= '0;
              o_bkt    <= '0;
              o_len    <= '0;
              o_off    <= '0;
              o_last   <= 1'b1;
              more2    <= 1'b0;
            end else begin
              m_tvalid <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      // common tail of a finished token: result, pointers, deferred byte
      if (fin_go) begin
        o_status <= fin_status;
        o_idx    <= (state == S_DONE) ? cnt[SYM_AW-1:0] : '0;
        o_bkt    <= (state == S_DONE) ? sum : '0;
        o_len    <= tok_len[6:0];
        o_off    <= ts[6:0];
        m_tvalid <= 1'b1;
        ts       <= fin_wp;
        wp       <= fin_wp;
        state    <= S_OUT;
        more2    <= 1'b0;
        o_last   <= 1'b1;
        if (st_pend) begin
          if (fin_room) begin
            wp        <= fin_wp + PTR_W'(1);
            sum       <= st_byte[BKT_W-1:0];
            first_dig <= is_digit(st_byte);
          end else begin
            o_last <= 1'b0;
            more2  <= 1'b1;
          end
        end
      end
    end
  end

  assign m_tdata = {o_off, o_len, o_bkt, o_idx};
  assign m_tuser = o_status;
  assign m_tlast = o_last;

`ifndef SYNTHESIS
  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == S_OUT)
    else $error("result shown outside the output state");
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input taken while a result waits");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(SYM_ENTRIES))
    else $error("symbol count beyond table");
  a_ptr_order: assert property (@(posedge clk) disable iff (rst)
    ts <= wp && wp <= PTR_W'(POOL_BYTES))
    else $error("pool pointers out of order");
  a_second_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && m_tready && more2) |=> (m_tvalid && m_tuser == ST_FULL && m_tlast))
    else $error("second result is not a full report");
`endif

endmodule

[sim/identifier_tokenize_and_intern_checker.sv]
// checker for the identifier tokenizer: predicts results from accepted words and compares
module identifier_tokenize_and_intern_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import iti_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] sym;
    logic [3:0] bkt;
    logic [6:0] len;
    logic [6:0] off;
    logic       last;
  } intern_res_t;

  intern_res_t expected_q[$];

  logic [7:0] pool [POOL_BYTES];
  int         sym_start [SYM_ENTRIES];
  int         sym_len [SYM_ENTRIES];
  int         sym_link [SYM_ENTRIES];
  int         heads [HASH_BUCKETS];
  int         wr_ptr, tok_start, sym_cnt;

  assign pending = expected_q.size();

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic intern_res_t make_res(input logic [1:0] st, input int sym, input int bkt,
                                           input int len, input int off);
    intern_res_t r;
    r.status = st;
    r.sym = sym[5:0];
    r.bkt = bkt[3:0];
    r.len = len[6:0];
    r.off = off[6:0];
    r.last = 1'b0;
    return r;
  endfunction

  function automatic intern_res_t close_token();
    int ts, len, sum, b, link, steps, e, idx;
    bit found, same;
    ts = tok_start;
    len = wr_ptr - tok_start;
    sum = 0;
    found = 0;
    if (pool[ts] >= CH_ZERO && pool[ts] <= CH_NINE) begin
      wr_ptr = ts;
      return make_res(ST_DIGIT, 0, 0, len, ts);
    end
    if (sym_cnt >= SYM_ENTRIES) begin
      wr_ptr = ts;
      return make_res(ST_FULL, 0, 0, len, ts);
    end
    for (int i = 0; i < len; i++) sum += pool[ts + i];
    b = sum % HASH_BUCKETS;
    link = heads[b];
    steps = 0;
    while (link != 0 && steps < SYM_ENTRIES && !found) begin
      e = link - 1;
      if (sym_len[e] == len) begin
        same = 1;
        for (int i = 0; i < len; i++)
          if (pool[sym_start[e] + i] != pool[ts + i]) same = 0;
        found = same;
      end
      link = sym_link[e];
      steps++;
    end
    idx = sym_cnt++;
    sym_start[idx] = ts;
    sym_len[idx] = len;
    if (!found) begin
      sym_link[idx] = heads[b];
      heads[b] = idx + 1;
    end
    tok_start = wr_ptr;
    return make_res(found ? ST_EXISTS : ST_NEW, idx, b, len, ts);
  endfunction

  task automatic predict_word(input logic kind, input logic [7:0] c);
    intern_res_t res[$];
    bit sep;
    if (kind) begin
      if (tok_start < wr_ptr) res.push_back(close_token());
    end else begin
      sep = c == CH_SPACE || c == CH_COMMA || c == CH_SEMI || c == CH_TAB ||
            c == CH_LF || c == CH_CR || c == CH_NUL;
      if ((sep || wr_ptr >= POOL_BYTES) && tok_start < wr_ptr) res.push_back(close_token());
      if (!sep) begin
        if (wr_ptr < POOL_BYTES) pool[wr_ptr++] = c;
        else res.push_back(make_res(ST_FULL, 0, 0, 0, 0));
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_q.push_back(res[i]);
  endtask

  always @(posedge clk) begin
    intern_res_t got, want;
    if (rst) begin
      expected_q.delete();
      foreach (heads[i]) heads[i] = 0;
      wr_ptr = 0;
      tok_start = 0;
      sym_cnt = 0;
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[5:0], m_tdata[9:6], m_tdata[16:10], m_tdata[23:17], m_tlast};
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result %h", got));
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.sym != want.sym) report($sformatf("symbol %0d, want %0d", got.sym, want.sym));
          if (got.bkt != want.bkt) report($sformatf("bucket %0d, want %0d", got.bkt, want.bkt));
          if (got.len != want.len) report($sformatf("length %0d, want %0d", got.len, want.len));
          if (got.off != want.off) report($sformatf("offset %0d, want %0d", got.off, want.off));
          if (got.last != want.last) report($sformatf("last %0b, want %0b", got.last, want.last));
        end
      end
      if (s_tvalid && s_tready) predict_word(s_tuser[0], s_tdata);
    end
  end
endmodule

[sim/identifier_tokenize_and_intern_core_test.sv]
// testbench top for the identifier tokenizer: word stimulus, receiver stalls and verdict
module identifier_tokenize_and_intern_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import iti_pkg::*;

  localparam int WATCHDOG = 200000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = 0;
  logic [0:0]  s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  int          errors, pending;
  bit          calm = 0;
  bit          hold_rx = 0;
  int          idle_cycles = 0;
  int          rx_stall = 0;

  always #1 clk = ~clk;

  identifier_tokenize_and_intern_core dut (.*);
  identifier_tokenize_and_intern_checker chk (.*);

  // receiver: random stall bursts, none in the calm phase or while held
  always @(negedge clk) begin
    if (rst || hold_rx) begin
      m_tready <= 0;
    end else if (rx_stall > 0) begin
      m_tready <= 0;
      rx_stall <= rx_stall - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      m_tready <= 0;
      rx_stall <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // leaves the word offered after its accepting edge; the next call or drain takes it down
  task automatic send_word(input logic kind, input logic [7:0] c);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= c;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_text(input string txt);
    foreach (txt[i]) send_word(1'b0, txt[i]);
  endtask

  function automatic logic [7:0] ident_char(input bit first);
    logic [7:0] set [4];
    set = '{8'h61, 8'h62, 8'h5f, 8'h7a};
    if (!first && $urandom_range(0, 5) == 0) return 8'(8'h30 + $urandom_range(0, 9));
    return set[$urandom_range(0, 3)];
  endfunction

  task automatic send_random(input int count);
    int n;
    n = 0;
    while (n < count) begin
      case ($urandom_range(0, 9))
        0: begin send_word(1'b0, 8'($urandom_range(0, 255))); n++; end
        1: begin send_word(1'b1, 8'($urandom_range(0, 255))); n++; end
        2: begin send_word(1'b0, 8'(8'h30 + $urandom_range(0, 9))); n++; end
        default: begin
          // short identifier from a small alphabet so repeats hit existing chains
          repeat ($urandom_range(1, 3)) begin
            send_word(1'b0, ident_char(n == 0)); n++;
          end
          send_word(1'b0, $urandom_range(0, 1) ? CH_SPACE : CH_SEMI); n++;
        end
      endcase
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic restart_stream();
    // fill the pool, then each later byte reports storage full
    repeat (3) begin
      for (int i = 0; i < 50; i++) send_word(1'b0, 8'(8'h41 + i % 26));
      send_word(1'b0, CH_COMMA);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // separators, digit token, repeats, flush, extremes of the byte
    send_text("ab ab,ba;9x\tq\nq\rz");
    send_word(1'b0, CH_NUL);
    send_word(1'b0, 8'hff);
    send_word(1'b0, 8'h80);
    send_word(1'b1, 8'hff);
    send_word(1'b1, 8'h00);
    send_word(1'b0, 8'h7f);
    send_word(1'b1, 8'h00);
    drain();
    // long receiver hold-off while words keep coming
    hold_rx <= 1;
    fork
      begin repeat (300) @(negedge clk); hold_rx <= 0; end
      send_random(60);
    join
    drain();
    send_random(300);
    drain();
    // pool and symbol table overflow
    restart_stream();
    send_word(1'b0, 8'h41);
    send_word(1'b0, CH_SPACE);
    send_random(200);
    drain();
    calm <= 1;
    send_random(200);
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

[filelist.f]
src/iti_pkg.sv
src/iti_pool.sv
src/identifier_tokenize_and_intern_core.sv
sim/identifier_tokenize_and_intern_checker.sv
sim/identifier_tokenize_and_intern_core_test.sv
